FILE: design/srks_pkg.sv
package srks_pkg;

    localparam int STORE_SLOTS = 4096;
    localparam int TOP_SECTION = 2048;
    localparam int KEY_W       = 32;
    localparam int LVL_W       = 4;
    localparam int ADDR_W      = $clog2(STORE_SLOTS);
    localparam int N_RUNS      = ADDR_W;
    localparam int RUN_W       = $clog2(N_RUNS);

    localparam logic [LVL_W-1:0] LVL_MAX = '1;

    typedef logic [ADDR_W-1:0] addr_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SKIP,
        OP_RUN_START,
        OP_BS_RD,
        OP_BS_CMP,
        OP_LO_RD,
        OP_HIT,
        OP_MISS,
        OP_INSERT,
        OP_M_INIT,
        OP_M_RD1,
        OP_M_LD1,
        OP_M_LD2,
        OP_M_STEP,
        OP_M_FILL,
        OP_M_NEXT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic run_live;
        logic b_zero;
        logic half_zero;
        logic hit;
        logic allow;
        logic src_lt_low;
        logic rem2_zero;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_BS_RD,
        S_BS_CMP,
        S_LO_CMP,
        S_INSERT,
        S_M_CHECK,
        S_M_RD1,
        S_M_LD1,
        S_M_LD2,
        S_M_STEP,
        S_M_FILL,
        S_DONE
    } ctrl_state_t;

endpackage

FILE: design/sorted_run_key_set.sv
// throughput: one item at a time, s_ready only in idle; the single read port sets the pace
// reset: synchronous active-low aresetn clears the run bitmap, top run mask and output
//   valid; the key store is not cleared and needs no clearing pass
module sorted_run_key_set (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [srks_pkg::KEY_W-1:0]  s_key,
    input  logic                        s_allow_insert,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [srks_pkg::LVL_W-1:0]  m_hit_level,
    output logic                        m_inserted,
    output logic                        m_flushed
);

    // command from the sequencer, status back from the datapath
    srks_pkg::dp_op_t     op;
    srks_pkg::dp_status_t status;

    // controller: scans runs largest first, binary-searches each live run,
    // then on a miss with insert allowed walks the carry merges
    srks_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    // datapath: key store, search and merge pointers, run bitmap,
    // and the result register that holds an item until it is taken
    srks_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .s_key          (s_key),
        .s_allow_insert (s_allow_insert),
        .m_ready        (m_ready),
        .status         (status),
        .m_valid        (m_valid),
        .m_found        (m_found),
        .m_hit_level    (m_hit_level),
        .m_inserted     (m_inserted),
        .m_flushed      (m_flushed)
    );

endmodule

FILE: design/srks_ctrl.sv
module srks_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  srks_pkg::dp_status_t status,
    output srks_pkg::dp_op_t     op
);

    srks_pkg::ctrl_state_t state_reg;
    srks_pkg::ctrl_state_t state_next;
    srks_pkg::ctrl_state_t scan_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srks_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        // where to go once every run has been searched without a hit
        scan_end   = status.allow ? srks_pkg::S_INSERT : srks_pkg::S_DONE;
        state_next = state_reg;
        op         = srks_pkg::OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            srks_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = srks_pkg::OP_LOAD;
                    state_next = srks_pkg::S_SCAN;
                end
            end
            srks_pkg::S_SCAN: begin
                if (status.run_live) begin
                    op         = srks_pkg::OP_RUN_START;
                    state_next = srks_pkg::S_BS_RD;
                end else if (status.b_zero) begin
                    state_next = scan_end;
                end else begin
                    op         = srks_pkg::OP_SKIP;
                    state_next = srks_pkg::S_SCAN;
                end
            end
            srks_pkg::S_BS_RD: begin
                if (status.half_zero) begin
                    op         = srks_pkg::OP_LO_RD;
                    state_next = srks_pkg::S_LO_CMP;
                end else begin
                    op         = srks_pkg::OP_BS_RD;
                    state_next = srks_pkg::S_BS_CMP;
                end
            end
            srks_pkg::S_BS_CMP: begin
                op         = srks_pkg::OP_BS_CMP;
                state_next = srks_pkg::S_BS_RD;
            end
            srks_pkg::S_LO_CMP: begin
                if (status.hit) begin
                    op         = srks_pkg::OP_HIT;
                    state_next = srks_pkg::S_DONE;
                end else begin
                    op         = srks_pkg::OP_MISS;
                    state_next = status.b_zero ? scan_end : srks_pkg::S_SCAN;
                end
            end
            srks_pkg::S_INSERT: begin
                op         = srks_pkg::OP_INSERT;
                state_next = srks_pkg::S_M_CHECK;
            end
            srks_pkg::S_M_CHECK: begin
                if (status.src_lt_low) begin
                    op         = srks_pkg::OP_M_INIT;
                    state_next = srks_pkg::S_M_RD1;
                end else begin
                    state_next = srks_pkg::S_DONE;
                end
            end
            srks_pkg::S_M_RD1: begin
                op         = srks_pkg::OP_M_RD1;
                state_next = srks_pkg::S_M_LD1;
            end
            srks_pkg::S_M_LD1: begin
                op         = srks_pkg::OP_M_LD1;
                state_next = srks_pkg::S_M_LD2;
            end
            srks_pkg::S_M_LD2: begin
                op         = srks_pkg::OP_M_LD2;
                state_next = srks_pkg::S_M_STEP;
            end
            srks_pkg::S_M_STEP: begin
                if (status.rem2_zero) begin
                    op         = srks_pkg::OP_M_NEXT;
                    state_next = srks_pkg::S_M_CHECK;
                end else begin
                    op         = srks_pkg::OP_M_STEP;
                    state_next = srks_pkg::S_M_FILL;
                end
            end
            srks_pkg::S_M_FILL: begin
                op         = srks_pkg::OP_M_FILL;
                state_next = srks_pkg::S_M_STEP;
            end
            srks_pkg::S_DONE: begin
                if (status.out_free) begin
                    op         = srks_pkg::OP_OUT;
                    state_next = srks_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = srks_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/srks_dp.sv
module srks_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  srks_pkg::dp_op_t                  op,
    input  logic [srks_pkg::KEY_W-1:0]        s_key,
    input  logic                              s_allow_insert,
    input  logic                              m_ready,
    output srks_pkg::dp_status_t              status,
    output logic                              m_valid,
    output logic                              m_found,
    output logic [srks_pkg::LVL_W-1:0]        m_hit_level,
    output logic                              m_inserted,
    output logic                              m_flushed
);

    // key store, read data registered
    logic [srks_pkg::KEY_W-1:0] mem [srks_pkg::STORE_SLOTS];
    logic [srks_pkg::KEY_W-1:0] rdata_reg;

    // control state
    srks_pkg::addr_t            bitmap_reg, bitmap_next;
    srks_pkg::addr_t            top_reg, top_next;
    logic                       mvalid_reg, mvalid_next;

    // working registers
    logic [srks_pkg::KEY_W-1:0] key_reg, key_next;
    logic                       allow_reg, allow_next;
    logic [srks_pkg::RUN_W-1:0] b_reg, b_next;
    logic [srks_pkg::LVL_W-1:0] level_reg, level_next;
    logic                       found_reg, found_next;
    logic                       ins_reg, ins_next;
    logic                       flush_reg, flush_next;
    srks_pkg::addr_t            lo_reg, lo_next;
    srks_pkg::addr_t            half_reg, half_next;
    srks_pkg::addr_t            low_reg, low_next;
    srks_pkg::addr_t            src_reg, src_next;
    srks_pkg::addr_t            c1_reg, c1_next;
    srks_pkg::addr_t            c2_reg, c2_next;
    srks_pkg::addr_t            d_reg, d_next;
    srks_pkg::addr_t            rem1_reg, rem1_next;
    srks_pkg::addr_t            rem2_reg, rem2_next;
    logic [srks_pkg::KEY_W-1:0] v1_reg, v1_next;
    logic [srks_pkg::KEY_W-1:0] v2_reg, v2_next;
    logic                       sel2_reg, sel2_next;
    logic                       mfound_reg, mfound_next;
    logic [srks_pkg::LVL_W-1:0] mlevel_reg, mlevel_next;
    logic                       mins_reg, mins_next;
    logic                       mflush_reg, mflush_next;

    // memory port
    srks_pkg::addr_t            rd_addr;
    srks_pkg::addr_t            wr_addr;
    logic                       wr_en;
    logic [srks_pkg::KEY_W-1:0] wr_data;

    srks_pkg::addr_t            run_mask;
    srks_pkg::addr_t            mid;
    srks_pkg::addr_t            ins_base;
    srks_pkg::addr_t            ins_sum;
    srks_pkg::addr_t            ins_low;
    logic                       ins_full;
    logic                       take2;

    assign run_mask = srks_pkg::ADDR_W'(1) << b_reg;
    assign mid      = lo_reg + half_reg;
    assign ins_full = (bitmap_reg == srks_pkg::ADDR_W'(srks_pkg::STORE_SLOTS - 1));
    assign ins_base = ins_full ? srks_pkg::ADDR_W'(srks_pkg::TOP_SECTION) : bitmap_reg;
    assign ins_sum  = ins_base + srks_pkg::ADDR_W'(1);
    assign ins_low  = ins_sum & ~ins_base;
    assign take2    = (rem1_reg == '0) || (v1_reg <= v2_reg);

    always_comb begin
        status.run_live   = bitmap_reg[b_reg] && (run_mask <= top_reg);
        status.b_zero     = (b_reg == '0);
        status.half_zero  = (half_reg == '0);
        status.hit        = (key_reg == rdata_reg);
        status.allow      = allow_reg;
        status.src_lt_low = (src_reg < low_reg);
        status.rem2_zero  = (rem2_reg == '0);
        status.out_free   = !mvalid_reg || m_ready;
    end

    always_comb begin
        bitmap_next = bitmap_reg;
        top_next    = top_reg;
        mvalid_next = (mvalid_reg && m_ready) ? 1'b0 : mvalid_reg;
        key_next    = key_reg;
        allow_next  = allow_reg;
        b_next      = b_reg;
        level_next  = level_reg;
        found_next  = found_reg;
        ins_next    = ins_reg;
        flush_next  = flush_reg;
        lo_next     = lo_reg;
        half_next   = half_reg;
        low_next    = low_reg;
        src_next    = src_reg;
        c1_next     = c1_reg;
        c2_next     = c2_reg;
        d_next      = d_reg;
        rem1_next   = rem1_reg;
        rem2_next   = rem2_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        sel2_next   = sel2_reg;
        mfound_next = mfound_reg;
        mlevel_next = mlevel_reg;
        mins_next   = mins_reg;
        mflush_next = mflush_reg;
        rd_addr     = lo_reg;
        wr_addr     = d_reg;
        wr_en       = 1'b0;
        wr_data     = key_reg;
        case (op)
            srks_pkg::OP_LOAD: begin
                key_next   = s_key;
                allow_next = s_allow_insert;
                b_next     = srks_pkg::RUN_W'(srks_pkg::N_RUNS - 1);
                level_next = '0;
                found_next = 1'b0;
                ins_next   = 1'b0;
                flush_next = 1'b0;
            end
            srks_pkg::OP_SKIP: begin
                b_next = b_reg - srks_pkg::RUN_W'(1);
            end
            srks_pkg::OP_RUN_START: begin
                lo_next   = run_mask;
                half_next = run_mask >> 1;
            end
            srks_pkg::OP_BS_RD: begin
                rd_addr = mid;
            end
            srks_pkg::OP_BS_CMP: begin
                if (key_reg >= rdata_reg) begin
                    lo_next = mid;
                end
                half_next = half_reg >> 1;
            end
            srks_pkg::OP_LO_RD: begin
                rd_addr = lo_reg;
            end
            srks_pkg::OP_HIT: begin
                found_next = 1'b1;
            end
            srks_pkg::OP_MISS: begin
                level_next = (level_reg == srks_pkg::LVL_MAX) ? level_reg
                                                              : level_reg + srks_pkg::LVL_W'(1);
                b_next     = b_reg - srks_pkg::RUN_W'(1);
            end
            srks_pkg::OP_INSERT: begin
                ins_next    = 1'b1;
                flush_next  = ins_full;
                bitmap_next = ins_sum;
                low_next    = ins_low;
                src_next    = srks_pkg::ADDR_W'(1);
                if (ins_low > top_reg) begin
                    top_next = ins_low;
                end
                wr_addr = ins_low;
                wr_data = key_reg;
                wr_en   = (ins_low != '0);
            end
            srks_pkg::OP_M_INIT: begin
                c1_next   = low_reg + src_reg - srks_pkg::ADDR_W'(1);
                c2_next   = (src_reg << 1) - srks_pkg::ADDR_W'(1);
                d_next    = low_reg + (src_reg << 1) - srks_pkg::ADDR_W'(1);
                rem1_next = src_reg;
                rem2_next = src_reg;
            end
            srks_pkg::OP_M_RD1: begin
                rd_addr = c1_reg;
            end
            srks_pkg::OP_M_LD1: begin
                v1_next = rdata_reg;
                rd_addr = c2_reg;
            end
            srks_pkg::OP_M_LD2: begin
                v2_next = rdata_reg;
            end
            srks_pkg::OP_M_STEP: begin
                wr_en     = 1'b1;
                wr_addr   = d_reg;
                d_next    = d_reg - srks_pkg::ADDR_W'(1);
                sel2_next = take2;
                if (take2) begin
                    wr_data   = v2_reg;
                    c2_next   = c2_reg - srks_pkg::ADDR_W'(1);
                    rem2_next = rem2_reg - srks_pkg::ADDR_W'(1);
                    rd_addr   = c2_reg - srks_pkg::ADDR_W'(1);
                end else begin
                    wr_data   = v1_reg;
                    c1_next   = c1_reg - srks_pkg::ADDR_W'(1);
                    rem1_next = rem1_reg - srks_pkg::ADDR_W'(1);
                    rd_addr   = c1_reg - srks_pkg::ADDR_W'(1);
                end
            end
            srks_pkg::OP_M_FILL: begin
                if (sel2_reg) begin
                    v2_next = rdata_reg;
                end else begin
                    v1_next = rdata_reg;
                end
            end
            srks_pkg::OP_M_NEXT: begin
                src_next = src_reg << 1;
            end
            srks_pkg::OP_OUT: begin
                mvalid_next = 1'b1;
                mfound_next = found_reg;
                mlevel_next = found_reg ? level_reg : '0;
                mins_next   = ins_reg;
                mflush_next = flush_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_reg <= '0;
            top_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            bitmap_reg <= bitmap_next;
            top_reg    <= top_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        allow_reg  <= allow_next;
        b_reg      <= b_next;
        level_reg  <= level_next;
        found_reg  <= found_next;
        ins_reg    <= ins_next;
        flush_reg  <= flush_next;
        lo_reg     <= lo_next;
        half_reg   <= half_next;
        low_reg    <= low_next;
        src_reg    <= src_next;
        c1_reg     <= c1_next;
        c2_reg     <= c2_next;
        d_reg      <= d_next;
        rem1_reg   <= rem1_next;
        rem2_reg   <= rem2_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        sel2_reg   <= sel2_next;
        mfound_reg <= mfound_next;
        mlevel_reg <= mlevel_next;
        mins_reg   <= mins_next;
        mflush_reg <= mflush_next;
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign m_valid     = mvalid_reg;
    assign m_found     = mfound_reg;
    assign m_hit_level = mlevel_reg;
    assign m_inserted  = mins_reg;
    assign m_flushed   = mflush_reg;

`ifndef ASSERT_OFF
    a_top_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(top_reg))
        else $error("top run mask holds more than one bit");

    a_runs_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (bitmap_reg == '0) || ({1'b0, bitmap_reg} < {top_reg, 1'b0}))
        else $error("run in use above top run");

    a_merge_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == srks_pkg::OP_M_STEP) |-> (wr_addr != rd_addr))
        else $error("merge write hits the slot being fetched");

    a_result_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg |-> (!(mfound_reg && mins_reg) && (!mflush_reg || mins_reg)))
        else $error("result flags contradict");

    a_level_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !mfound_reg) |-> (mlevel_reg == '0))
        else $error("hit level set without a hit");
`endif

endmodule
